// ===== src/abkf_pkg.sv =====
// Package with shared types, constants and the sequencer state type of the angle and bias filter.
`timescale 1ns / 1ps
`default_nettype none

package abkf_pkg;

    localparam int DATA_W   = 32;
    localparam int DT_W     = 24;
    localparam int FRAC_COV = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] ANGLE_NOISE_RST   = 32'd16777;
    localparam logic [DATA_W-1:0] BIAS_NOISE_RST    = 32'd50332;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd503316;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_NOISE   = 2'd0,
        CFG_BIAS_NOISE    = 2'd1,
        CFG_MEASURE_NOISE = 2'd2,
        CFG_START_ANGLE   = 2'd3
    } cfg_idx_t;

    // Sequencer steps; a step uses at most one multiplication or one division.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_M_ANG,
        ST_M_T,
        ST_PRED_S,
        ST_M_P00,
        ST_M_P11,
        ST_INN,
        ST_DIV0_START,
        ST_DIV0_WAIT,
        ST_DIV1_START,
        ST_DIV1_WAIT,
        ST_M_K0Y,
        ST_M_K1Y,
        ST_M_K0P00,
        ST_M_K0P01,
        ST_M_K1P00,
        ST_M_K1P01,
        ST_OUT
    } seq_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -66'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/abkf_if.sv =====
// Valid/ready channel interface with a generic payload.
`timescale 1ns / 1ps
`default_nettype none

interface abkf_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/abkf_mul.sv =====
// Shared signed multiplier with a registered, rounded and scaled product.
`timescale 1ns / 1ps
`default_nettype none

module abkf_mul (
    input  wire                 clk,
    input  wire signed [32:0]   a,
    input  wire signed [32:0]   b,
    output logic signed [65:0]  q
);
    import abkf_pkg::*;

    logic signed [65:0] prod;
    logic signed [65:0] q_next;

    // Round to nearest with ties upward, then drop the fraction bits.
    assign prod   = a * b;
    assign q_next = (prod + (66'sd1 <<< (FRAC_COV - 1))) >>> FRAC_COV;

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end
endmodule

`default_nettype wire

// ===== src/abkf_div.sv =====
// Restoring divider: signed numerator by positive divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module abkf_div (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire signed [31:0]  num,
    input  wire signed [33:0]  den,
    output logic               done,
    output logic signed [31:0] quo
);
    import abkf_pkg::*;

    localparam int NW = 56;

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [NW-1:0] num_reg, num_next;
    logic [33:0]   den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NW:0]   trial;
    logic [NW-1:0] shifted;
    logic [31:0]   mag;
    logic signed [65:0] qs;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[NW-2:0], num_reg[NW-1]};
        trial     = {1'b0, shifted} - {{(NW-34+1){1'b0}}, den_reg};
        mag       = num[31] ? 32'(-num) : num;
        if (start)
        begin
            num_next  = {mag, {FRAC_COV{1'b0}}};
            den_next  = den;
            neg_next  = num[31];
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (!trial[NW])
            begin
                rem_next = trial[NW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    assign qs   = neg_reg ? -$signed({10'd0, quo_next}) : $signed({10'd0, quo_next});
    assign quo  = sat32(qs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end
endmodule

`default_nettype wire

// ===== src/angle_bias_kalman_filter_unit.sv =====
// Top level: two-state angle and gyro bias filter on one multiplier and one divider.
//
//  channel   direction  payload
//  in_ch     sink       measured_angle, measured_rate, step_time
//  out_ch    source     angle_estimate, unbiased_rate, bias_estimate
//  cfg       write      cfg_we, cfg_idx, cfg_data
//
// An item passes from acceptance through ten multiplier steps, bookkeeping
// steps and two divisions on the shared serial divider. When the innovation
// variance is not positive both divisions are skipped. Reset restores the
// noise registers to their defaults and clears the state. The block takes no
// new item until its result has been taken from out_ch.
`timescale 1ns / 1ps
`default_nettype none

module angle_bias_kalman_filter_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [abkf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire [abkf_pkg::DATA_W-1:0]   cfg_data,
    abkf_if.sink                         in_ch,
    abkf_if.source                       out_ch
);
    import abkf_pkg::*;

    seq_state_t state_reg, state_next;

    logic [31:0] angle_noise_reg, bias_noise_reg, measure_noise_reg;
    logic signed [31:0] angle_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] z_reg, w_reg, rate_reg, s_reg, k0_reg, k1_reg, y_reg;
    logic signed [31:0] p00o_reg, p01o_reg;
    logic [23:0]        dt_reg;
    logic signed [33:0] inn_reg;
    logic               out_valid_reg;
    logic signed [31:0] o_ang_reg, o_rate_reg, o_bias_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] mq;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_q;
    logic signed [33:0] dt_s;

    abkf_mul u_mul (.clk(clk), .a(ma), .b(mb), .q(mq));
    abkf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(inn_reg), .done(div_done), .quo(div_q)
    );

    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data.angle_estimate = o_ang_reg;
    assign out_ch.data.unbiased_rate  = o_rate_reg;
    assign out_ch.data.bias_estimate  = o_bias_reg;
    assign dt_s = {10'd0, dt_reg};

    // Operand selection: each product issued in a state is read back in the next.
    always_comb
    begin
        ma = '0;
        mb = '0;
        div_start = 1'b0;
        div_num   = p00_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_ch.valid && in_ch.ready) state_next = ST_RATE;
            ST_RATE:       state_next = ST_M_ANG;
            ST_M_ANG:
            begin
                ma = 33'(rate_reg); mb = 33'(dt_s);
                state_next = ST_M_T;
            end
            ST_M_T:
            begin
                ma = 33'(dt_s); mb = 33'(p11_reg);
                state_next = ST_PRED_S;
            end
            ST_PRED_S:     state_next = ST_M_P00;
            ST_M_P00:
            begin
                ma = 33'(dt_s); mb = 33'(s_reg);
                state_next = ST_M_P11;
            end
            ST_M_P11:
            begin
                ma = $signed({1'b0, bias_noise_reg}); mb = 33'(dt_s);
                state_next = ST_INN;
            end
            ST_INN:        state_next = ST_DIV0_START;
            ST_DIV0_START:
            begin
                if (inn_reg > 34'sd0)
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV0_WAIT;
                end
                else
                    state_next = ST_M_K0Y;
            end
            ST_DIV0_WAIT:  if (div_done) state_next = ST_DIV1_START;
            ST_DIV1_START:
            begin
                div_start = 1'b1;
                div_num = p10_reg;
                state_next = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT:  if (div_done) state_next = ST_M_K0Y;
            ST_M_K0Y:
            begin
                ma = 33'(k0_reg); mb = 33'(y_reg);
                state_next = ST_M_K1Y;
            end
            ST_M_K1Y:
            begin
                ma = 33'(k1_reg); mb = 33'(y_reg);
                state_next = ST_M_K0P00;
            end
            ST_M_K0P00:
            begin
                ma = 33'(k0_reg); mb = 33'(p00o_reg);
                state_next = ST_M_K0P01;
            end
            ST_M_K0P01:
            begin
                ma = 33'(k0_reg); mb = 33'(p01o_reg);
                state_next = ST_M_K1P00;
            end
            ST_M_K1P00:
            begin
                ma = 33'(k1_reg); mb = 33'(p00o_reg);
                state_next = ST_M_K1P01;
            end
            ST_M_K1P01:
            begin
                ma = 33'(k1_reg); mb = 33'(p01o_reg);
                state_next = ST_OUT;
            end
            ST_OUT:        state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            angle_reg <= '0;
            bias_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
            s_reg     <= '0;
            inn_reg   <= '0;
            y_reg     <= '0;
            p00o_reg  <= '0;
            p01o_reg  <= '0;
            k0_reg    <= '0;
            k1_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_idx))
                    CFG_ANGLE_NOISE:   angle_noise_reg <= cfg_data;
                    CFG_BIAS_NOISE:    bias_noise_reg <= cfg_data;
                    CFG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    CFG_START_ANGLE:   angle_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_M_T:     angle_reg <= sat32(66'(angle_reg) + mq);
                ST_PRED_S:
                begin
                    s_reg <= sat32(mq - 66'(p01_reg) - 66'(p10_reg)
                                   + $signed({34'd0, angle_noise_reg}));
                    p01_reg <= sat32(66'(p01_reg) - mq);
                    p10_reg <= sat32(66'(p10_reg) - mq);
                end
                ST_M_P11:   p00_reg <= sat32(66'(p00_reg) + mq);
                ST_INN:
                begin
                    p11_reg <= sat32(66'(p11_reg) + mq);
                    inn_reg <= 34'(p00_reg) + $signed({2'd0, measure_noise_reg});
                    y_reg   <= sat32(66'(z_reg) - 66'(angle_reg));
                    p00o_reg <= p00_reg;
                    p01o_reg <= p01_reg;
                    k0_reg <= '0;
                    k1_reg <= '0;
                end
                ST_DIV0_WAIT: if (div_done) k0_reg <= div_q;
                ST_DIV1_WAIT: if (div_done) k1_reg <= div_q;
                ST_M_K1Y:   angle_reg <= sat32(66'(angle_reg) + mq);
                ST_M_K0P00: bias_reg  <= sat32(66'(bias_reg) + mq);
                ST_M_K0P01: p00_reg   <= sat32(66'(p00_reg) - mq);
                ST_M_K1P00: p01_reg   <= sat32(66'(p01_reg) - mq);
                ST_M_K1P01: p10_reg   <= sat32(66'(p10_reg) - mq);
                ST_OUT:
                begin
                    p11_reg       <= sat32(66'(p11_reg) - mq);
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            z_reg  <= in_ch.data.measured_angle;
            w_reg  <= in_ch.data.measured_rate;
            dt_reg <= in_ch.data.step_time;
        end
        if (state_reg == ST_RATE)
            rate_reg <= sat32(66'(w_reg) - 66'(bias_reg));
        if (state_reg == ST_OUT)
        begin
            o_ang_reg  <= angle_reg;
            o_rate_reg <= rate_reg;
            o_bias_reg <= bias_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> inn_reg > 34'sd0) else $error("divide by non-positive");
`endif
endmodule

`default_nettype wire
